>>> hdl/src_tok_pkg.sv
// Shared types, codes and character tables for the source tokenizer.
package src_tok_pkg;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       src_last;
    } src_beat_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [1:0]  error_code;
        logic [23:0] token_start;
        logic [15:0] token_length;
        logic [15:0] token_line;
        logic [15:0] token_col;
        logic        result_last;
    } token_t;

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [2:0]            count;
        token_t [MAX_RESULTS-1:0] tok;
    } tok_batch_t;

    typedef enum logic [7:0] {
        MODE_IDLE  = 8'b0000_0001,
        MODE_LINE  = 8'b0000_0010,
        MODE_BOPEN = 8'b0000_0100,
        MODE_BLOCK = 8'b0000_1000,
        MODE_NUM   = 8'b0001_0000,
        MODE_STR   = 8'b0010_0000,
        MODE_IDENT = 8'b0100_0000,
        MODE_DONE  = 8'b1000_0000
    } mode_t;

    localparam logic [4:0] KIND_INT_LIT   = 5'd0;
    localparam logic [4:0] KIND_FLOAT_LIT = 5'd1;
    localparam logic [4:0] KIND_STR_LIT   = 5'd2;
    localparam logic [4:0] KIND_IDENT     = 5'd3;
    localparam logic [4:0] KIND_KW_BASE   = 5'd4;
    localparam logic [4:0] KIND_PLUS      = 5'd12;
    localparam logic [4:0] KIND_MINUS     = 5'd13;
    localparam logic [4:0] KIND_STAR      = 5'd14;
    localparam logic [4:0] KIND_SLASH     = 5'd15;
    localparam logic [4:0] KIND_PERCENT   = 5'd16;
    localparam logic [4:0] KIND_LPAREN    = 5'd17;
    localparam logic [4:0] KIND_RPAREN    = 5'd18;
    localparam logic [4:0] KIND_LBRACE    = 5'd19;
    localparam logic [4:0] KIND_RBRACE    = 5'd20;
    localparam logic [4:0] KIND_LBRACKET  = 5'd21;
    localparam logic [4:0] KIND_RBRACKET  = 5'd22;
    localparam logic [4:0] KIND_DOT       = 5'd23;
    localparam logic [4:0] KIND_COMMA     = 5'd24;
    localparam logic [4:0] KIND_EOF       = 5'd25;
    localparam logic [4:0] KIND_ERR       = 5'd26;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    localparam logic [7:0] BOM_0 = 8'hEF;
    localparam logic [7:0] BOM_1 = 8'hBB;
    localparam logic [7:0] BOM_2 = 8'hBF;

    localparam int NUM_KW = 8;

    // last five bytes of the word, oldest in the top byte
    localparam logic [39:0] KW_WORD [NUM_KW] = '{
        40'h00_6675_6E63,   // func
        40'h00_006C_6574,   // let
        40'h00_006D_7574,   // mut
        40'h00_7569_6E74,   // uint
        40'h00_0069_6E74,   // int
        40'h66_6C6F_6174,   // float
        40'h00_626F_6F6C,   // bool
        40'h00_0073_7472    // str
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd4, 3'd3, 3'd3, 3'd4, 3'd3, 3'd5, 3'd4, 3'd3
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_digit(c) || is_alpha(c) || (c == CH_UNDERSCORE);
    endfunction

    // {hit, kind}
    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            CH_PLUS:     r = {1'b1, KIND_PLUS};
            CH_MINUS:    r = {1'b1, KIND_MINUS};
            CH_STAR:     r = {1'b1, KIND_STAR};
            CH_SLASH:    r = {1'b1, KIND_SLASH};
            CH_PERCENT:  r = {1'b1, KIND_PERCENT};
            CH_LPAREN:   r = {1'b1, KIND_LPAREN};
            CH_RPAREN:   r = {1'b1, KIND_RPAREN};
            CH_LBRACE:   r = {1'b1, KIND_LBRACE};
            CH_RBRACE:   r = {1'b1, KIND_RBRACE};
            CH_LBRACKET: r = {1'b1, KIND_LBRACKET};
            CH_RBRACKET: r = {1'b1, KIND_RBRACKET};
            CH_DOT:      r = {1'b1, KIND_DOT};
            CH_COMMA:    r = {1'b1, KIND_COMMA};
            default:     r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/source_tokenizer_top.sv
// Top level of the streaming source tokenizer.
//
// Source bytes come in on the s_ channel, one byte a beat; s_data.src_last marks the
// final byte of a text. Tokens leave on the m_ channel, one token a beat, with
// m_data.result_last set on the last token that a given byte produced.
// A byte's tokens (zero to four) are worked out in the cycle it is accepted and are
// on m_ the next cycle.
// Throughput is one byte a cycle while m_ready is high and each byte yields at most one
// token. A byte that yields more holds the next byte off until they drain, since the
// four-slot result register drains one token a beat and takes a new byte only on its last.
// The lexer holds one byte back for lookahead, so a token usually leaves on the
// beat of the byte after it ends.
// When m_ready is low a non-empty result register holds and s_ready drops; a byte with
// no tokens still needs the result register empty or draining.
// Reset (aresetn low, synchronous) clears the lexer to the start of a new text and
// empties the result register. After src_last the lexer returns to that state.
module source_tokenizer_top #(
    parameter int OFFSET_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  src_tok_pkg::src_beat_t s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output src_tok_pkg::token_t    m_data
);

    src_tok_pkg::tok_batch_t batch;
    logic                    s_accept;

    assign s_accept = s_valid && s_ready;

    src_tok_lexer #(
        .OFFSET_BITS (OFFSET_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .in_accept (s_accept),
        .batch     (batch)
    );

    src_tok_out_buf u_out_buf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .batch       (batch),
        .batch_valid (s_valid),
        .batch_ready (s_ready),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

    // a stalled token must block new source bytes
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("source byte accepted while a token is stalled");

    a_end_token_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_data.token_kind == src_tok_pkg::KIND_EOF)
            || (m_data.token_kind == src_tok_pkg::KIND_ERR))) |-> m_data.result_last)
        else $error("EOF or ERR token not last for its byte");

    a_err_code_only_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.token_kind == src_tok_pkg::KIND_ERR)
            == (m_data.error_code != src_tok_pkg::ERR_NONE)))
        else $error("error code and token kind disagree");

endmodule

>>> hdl/src_tok_lexer.sv
// Lexer state register and the single-pass next-state and token logic for one byte.
module src_tok_lexer #(
    parameter int OFFSET_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  src_tok_pkg::src_beat_t  in_data,
    input  logic                    in_accept,
    output src_tok_pkg::tok_batch_t batch
);

    typedef struct packed {
        src_tok_pkg::mode_t      mode;
        logic [7:0]              held_byte;
        logic                    held_valid;
        logic                    after_cr;
        logic [1:0]              bom_matched;
        logic [OFFSET_BITS-1:0]  byte_offset;
        logic [COUNT_BITS-1:0]   cur_line;
        logic [COUNT_BITS-1:0]   cur_col;
        logic [OFFSET_BITS-1:0]  tok_start;
        logic [COUNT_BITS-1:0]   tok_line;
        logic [COUNT_BITS-1:0]   tok_col;
        logic [COUNT_BITS-1:0]   tok_len;
        logic [39:0]             word_buffer;
        logic                    is_float;
        logic                    star_seen;
    } lex_state_t;

    typedef struct packed {
        lex_state_t              st;
        src_tok_pkg::tok_batch_t res;
    } work_t;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [COUNT_BITS-1:0]  CNT_MAX = '1;

    lex_state_t state_reg;
    lex_state_t state_next;
    work_t      work;
    logic       take;
    logic [7:0] cbyte;

    function automatic lex_state_t reset_state();
        lex_state_t s;
        s          = '0;
        s.mode     = src_tok_pkg::MODE_IDLE;
        s.cur_line = COUNT_BITS'(1);
        s.cur_col  = COUNT_BITS'(1);
        s.tok_line = COUNT_BITS'(1);
        s.tok_col  = COUNT_BITS'(1);
        return s;
    endfunction

    function automatic logic [23:0] to_start(input logic [OFFSET_BITS-1:0] x);
        logic [OFFSET_BITS+23:0] t;
        t = {24'd0, x};
        return t[23:0];
    endfunction

    function automatic logic [15:0] to_cnt(input logic [COUNT_BITS-1:0] x);
        logic [COUNT_BITS+15:0] t;
        t = {16'd0, x};
        return t[15:0];
    endfunction

    function automatic work_t emit(input work_t w, input logic [4:0] kind,
                                   input logic [1:0] err, input logic [23:0] start,
                                   input logic [15:0] len, input logic [15:0] line,
                                   input logic [15:0] col);
        src_tok_pkg::token_t t;
        t.token_kind   = kind;
        t.error_code   = err;
        t.token_start  = start;
        t.token_length = len;
        t.token_line   = line;
        t.token_col    = col;
        t.result_last  = 1'b0;
        if (w.res.count != 3'd4) begin
            w.res.tok[w.res.count[1:0]] = t;
            w.res.count = w.res.count + 3'd1;
        end
        return w;
    endfunction

    function automatic work_t emit_tok(input work_t w, input logic [4:0] kind);
        return emit(w, kind, src_tok_pkg::ERR_NONE, to_start(w.st.tok_start),
                    to_cnt(w.st.tok_len), to_cnt(w.st.tok_line), to_cnt(w.st.tok_col));
    endfunction

    function automatic lex_state_t advance(input lex_state_t s, input logic [7:0] c);
        if (s.byte_offset != OFF_MAX) s.byte_offset = s.byte_offset + OFFSET_BITS'(1);
        if (c == src_tok_pkg::CH_LF) begin
            if (s.cur_line != CNT_MAX) s.cur_line = s.cur_line + COUNT_BITS'(1);
            s.cur_col = COUNT_BITS'(1);
        end else if (s.cur_col != CNT_MAX) begin
            s.cur_col = s.cur_col + COUNT_BITS'(1);
        end
        if (s.tok_len != CNT_MAX) s.tok_len = s.tok_len + COUNT_BITS'(1);
        return s;
    endfunction

    function automatic lex_state_t begin_tok(input lex_state_t s);
        s.tok_start   = s.byte_offset;
        s.tok_line    = s.cur_line;
        s.tok_col     = s.cur_col;
        s.tok_len     = '0;
        s.is_float    = 1'b0;
        s.word_buffer = '0;
        return s;
    endfunction

    function automatic logic [4:0] ident_kind(input lex_state_t s);
        logic [4:0] k;
        k = src_tok_pkg::KIND_IDENT;
        for (int i = 0; i < src_tok_pkg::NUM_KW; i++) begin
            if ((s.tok_len == COUNT_BITS'(src_tok_pkg::KW_LEN[i]))
                    && (s.word_buffer == src_tok_pkg::KW_WORD[i])) begin
                k = src_tok_pkg::KIND_KW_BASE + 5'(i);
            end
        end
        return k;
    endfunction

    // one character at the current position, with one character of lookahead
    function automatic work_t consume(input work_t w, input logic [7:0] c,
                                      input logic [7:0] nx, input logic nx_ok);
        logic       redo;
        logic       nx_digit;
        logic [5:0] pk;
        redo     = 1'b0;
        nx_digit = nx_ok && src_tok_pkg::is_digit(nx);
        pk       = src_tok_pkg::punct_kind(c);
        case (w.st.mode)
            src_tok_pkg::MODE_IDENT: begin
                if (src_tok_pkg::is_word(c)) begin
                    w.st.word_buffer = {w.st.word_buffer[31:0], c};
                    w.st = advance(w.st, c);
                end else begin
                    w = emit_tok(w, ident_kind(w.st));
                    w.st.mode = src_tok_pkg::MODE_IDLE;
                    redo = 1'b1;
                end
            end
            src_tok_pkg::MODE_NUM: begin
                if (src_tok_pkg::is_digit(c) || (c == src_tok_pkg::CH_DOT)
                        || ((c == src_tok_pkg::CH_UNDERSCORE) && nx_digit)) begin
                    if (c == src_tok_pkg::CH_DOT) w.st.is_float = 1'b1;
                    w.st = advance(w.st, c);
                end else begin
                    w = emit_tok(w, w.st.is_float ? src_tok_pkg::KIND_FLOAT_LIT
                                                  : src_tok_pkg::KIND_INT_LIT);
                    w.st.mode = src_tok_pkg::MODE_IDLE;
                    redo = 1'b1;
                end
            end
            src_tok_pkg::MODE_STR: begin
                w.st = advance(w.st, c);
                if (c == src_tok_pkg::CH_DQUOTE) begin
                    w = emit_tok(w, src_tok_pkg::KIND_STR_LIT);
                    w.st.mode = src_tok_pkg::MODE_IDLE;
                end
            end
            src_tok_pkg::MODE_LINE: begin
                if (c == src_tok_pkg::CH_LF) begin
                    w.st.mode = src_tok_pkg::MODE_IDLE;
                    redo = 1'b1;
                end else begin
                    w.st = advance(w.st, c);
                end
            end
            src_tok_pkg::MODE_BOPEN: begin
                w.st = advance(w.st, c);
                w.st.mode = src_tok_pkg::MODE_BLOCK;
                w.st.star_seen = 1'b0;
            end
            src_tok_pkg::MODE_BLOCK: begin
                if (w.st.star_seen) begin
                    w.st.star_seen = 1'b0;
                    w.st.mode = src_tok_pkg::MODE_IDLE;
                end else if ((c == src_tok_pkg::CH_STAR) && nx_ok
                        && (nx == src_tok_pkg::CH_SLASH)) begin
                    w.st.star_seen = 1'b1;
                end
                w.st = advance(w.st, c);
            end
            src_tok_pkg::MODE_DONE: begin
                redo = 1'b0;
            end
            default: begin
                redo = 1'b1;
            end
        endcase
        if (redo) begin
            if ((c == src_tok_pkg::CH_SPACE) || (c == src_tok_pkg::CH_TAB)
                    || (c == src_tok_pkg::CH_LF) || (c == src_tok_pkg::CH_CR)) begin
                w.st = advance(w.st, c);
            end else if ((c == src_tok_pkg::CH_SLASH) && nx_ok
                    && (nx == src_tok_pkg::CH_SLASH)) begin
                w.st = advance(w.st, c);
                w.st.mode = src_tok_pkg::MODE_LINE;
            end else if ((c == src_tok_pkg::CH_SLASH) && nx_ok
                    && (nx == src_tok_pkg::CH_STAR)) begin
                w.st = advance(w.st, c);
                w.st.mode = src_tok_pkg::MODE_BOPEN;
            end else if (src_tok_pkg::is_digit(c)
                    || ((c == src_tok_pkg::CH_MINUS) && nx_digit)) begin
                w.st = begin_tok(w.st);
                w.st = advance(w.st, c);
                w.st.mode = src_tok_pkg::MODE_NUM;
            end else if (c == src_tok_pkg::CH_DQUOTE) begin
                w.st = begin_tok(w.st);
                w.st = advance(w.st, c);
                w.st.mode = src_tok_pkg::MODE_STR;
            end else if (src_tok_pkg::is_alpha(c) || (c == src_tok_pkg::CH_UNDERSCORE)) begin
                w.st = begin_tok(w.st);
                w.st.word_buffer = {32'd0, c};
                w.st = advance(w.st, c);
                w.st.mode = src_tok_pkg::MODE_IDENT;
            end else if (pk[5]) begin
                w.st = begin_tok(w.st);
                w.st = advance(w.st, c);
                w = emit_tok(w, pk[4:0]);
            end else begin
                w = emit(w, src_tok_pkg::KIND_ERR, src_tok_pkg::ERR_UNEXPECTED,
                         to_start(w.st.byte_offset), 16'd1, to_cnt(w.st.cur_line),
                         to_cnt(w.st.cur_col));
                w.st.mode = src_tok_pkg::MODE_DONE;
            end
        end
        return w;
    endfunction

    function automatic work_t feed(input work_t w, input logic [7:0] c);
        if (w.st.mode != src_tok_pkg::MODE_DONE) begin
            if (w.st.held_valid) w = consume(w, w.st.held_byte, c, 1'b1);
            w.st.held_byte  = c;
            w.st.held_valid = 1'b1;
        end
        return w;
    endfunction

    // a partial mark at the head of the text always lexes to one error at the start
    function automatic work_t replay_bom(input work_t w);
        logic [1:0] n;
        n = w.st.bom_matched;
        w.st.bom_matched = 2'd3;
        if ((n == 2'd1) || (n == 2'd2)) begin
            w = emit(w, src_tok_pkg::KIND_ERR, src_tok_pkg::ERR_UNEXPECTED,
                     to_start(w.st.byte_offset), 16'd1, to_cnt(w.st.cur_line),
                     to_cnt(w.st.cur_col));
            w.st.mode = src_tok_pkg::MODE_DONE;
        end
        return w;
    endfunction

    function automatic work_t finish(input work_t w);
        w = replay_bom(w);
        if (w.st.mode != src_tok_pkg::MODE_DONE) begin
            if (w.st.held_valid) begin
                w.st.held_valid = 1'b0;
                w = consume(w, w.st.held_byte, src_tok_pkg::CH_NUL, 1'b0);
            end
            if (w.st.mode != src_tok_pkg::MODE_DONE) begin
                if (w.st.mode == src_tok_pkg::MODE_NUM) begin
                    w = emit_tok(w, w.st.is_float ? src_tok_pkg::KIND_FLOAT_LIT
                                                  : src_tok_pkg::KIND_INT_LIT);
                end else if (w.st.mode == src_tok_pkg::MODE_IDENT) begin
                    w = emit_tok(w, ident_kind(w.st));
                end
                if (w.st.mode == src_tok_pkg::MODE_STR) begin
                    w = emit(w, src_tok_pkg::KIND_ERR, src_tok_pkg::ERR_UNTERM_STR,
                             to_start(w.st.tok_start), to_cnt(w.st.tok_len),
                             to_cnt(w.st.tok_line), to_cnt(w.st.tok_col));
                end else begin
                    w = emit(w, src_tok_pkg::KIND_EOF, src_tok_pkg::ERR_NONE,
                             to_start(w.st.byte_offset), 16'd0, to_cnt(w.st.cur_line),
                             to_cnt(w.st.cur_col));
                end
                w.st.mode = src_tok_pkg::MODE_DONE;
            end
        end
        return w;
    endfunction

    function automatic logic [7:0] bom_byte(input logic [1:0] n);
        logic [7:0] r;
        case (n)
            2'd0:    r = src_tok_pkg::BOM_0;
            2'd1:    r = src_tok_pkg::BOM_1;
            default: r = src_tok_pkg::BOM_2;
        endcase
        return r;
    endfunction

    always_comb begin
        work.st  = state_reg;
        work.res = '0;
        take     = 1'b1;
        cbyte    = in_data.src_byte;
        if (work.st.mode != src_tok_pkg::MODE_DONE) begin
            if (work.st.bom_matched != 2'd3) begin
                if (in_data.src_byte == bom_byte(work.st.bom_matched)) begin
                    work.st.bom_matched = work.st.bom_matched + 2'd1;
                    take = 1'b0;
                end else begin
                    work = replay_bom(work);
                end
            end
            if (take && (work.st.mode != src_tok_pkg::MODE_DONE)) begin
                if (work.st.after_cr && (in_data.src_byte == src_tok_pkg::CH_LF)) begin
                    work.st.after_cr = 1'b0;
                end else begin
                    work.st.after_cr = (in_data.src_byte == src_tok_pkg::CH_CR);
                    if (in_data.src_byte == src_tok_pkg::CH_CR) cbyte = src_tok_pkg::CH_LF;
                    if (cbyte == src_tok_pkg::CH_NUL) work = finish(work);
                    else work = feed(work, cbyte);
                end
            end
        end
        if (in_data.src_last) begin
            if (work.st.mode != src_tok_pkg::MODE_DONE) work = finish(work);
            work.st = reset_state();
        end
        if (work.res.count != 3'd0) begin
            work.res.tok[work.res.count[1:0] - 2'd1].result_last = 1'b1;
        end
        state_next = work.st;
        batch      = work.res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= reset_state();
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/src_tok_out_buf.sv
// Four-slot result register that holds the tokens of one byte and drains them one a beat.
module src_tok_out_buf (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  src_tok_pkg::tok_batch_t batch,
    input  logic                    batch_valid,
    output logic                    batch_ready,
    output src_tok_pkg::token_t     m_data,
    output logic                    m_valid,
    input  logic                    m_ready
);

    src_tok_pkg::token_t slot_reg [src_tok_pkg::MAX_RESULTS];
    logic [1:0] head_reg;
    logic [1:0] head_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;
    logic       load;

    assign m_valid     = (count_reg != 3'd0);
    assign m_data      = slot_reg[head_reg];
    assign pop         = m_valid && m_ready;
    assign batch_ready = (count_reg == 3'd0) || ((count_reg == 3'd1) && m_ready);
    assign load        = batch_valid && batch_ready;

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (load) begin
            head_next  = 2'd0;
            count_next = batch.count;
        end else if (pop) begin
            head_next  = head_reg + 2'd1;
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < src_tok_pkg::MAX_RESULTS; i++) begin
                slot_reg[i] <= batch.tok[i];
            end
        end
    end

endmodule

>>> tb/token_scoreboard.sv
// Token predictor and result checker for the source tokenizer testbench.
`timescale 1ns / 100ps
module token_scoreboard (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  src_tok_pkg::src_beat_t s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  src_tok_pkg::token_t    m_data,
    output int                     fail_count,
    output int                     pending
);

    src_tok_pkg::token_t expected_tokens[$];
    src_tok_pkg::mode_t  scan_mode;
    int          held_byte;
    bit          held_valid;
    bit          after_cr;
    int          bom_matched;
    logic [23:0] byte_offset;
    logic [23:0] tok_start;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [15:0] tok_len;
    logic [39:0] word_buffer;
    bit          is_float;
    bit          star_seen;
    int          step_count;

    const string kw_names [8] = '{"func", "let", "mut", "uint", "int", "float", "bool", "str"};
    const logic [7:0] bom_seq [3] = '{src_tok_pkg::BOM_0, src_tok_pkg::BOM_1,
                                      src_tok_pkg::BOM_2};

    function automatic bit digit_ch(int c);
        return c >= 48 && c <= 57;
    endfunction

    function automatic bit alpha_ch(int c);
        return (c >= 97 && c <= 122) || (c >= 65 && c <= 90);
    endfunction

    function automatic bit word_ch(int c);
        return digit_ch(c) || alpha_ch(c) || c == 95;
    endfunction

    function automatic int punct_of(int c);
        case (c)
            src_tok_pkg::CH_PLUS:     return src_tok_pkg::KIND_PLUS;
            src_tok_pkg::CH_MINUS:    return src_tok_pkg::KIND_MINUS;
            src_tok_pkg::CH_STAR:     return src_tok_pkg::KIND_STAR;
            src_tok_pkg::CH_SLASH:    return src_tok_pkg::KIND_SLASH;
            src_tok_pkg::CH_PERCENT:  return src_tok_pkg::KIND_PERCENT;
            src_tok_pkg::CH_LPAREN:   return src_tok_pkg::KIND_LPAREN;
            src_tok_pkg::CH_RPAREN:   return src_tok_pkg::KIND_RPAREN;
            src_tok_pkg::CH_LBRACE:   return src_tok_pkg::KIND_LBRACE;
            src_tok_pkg::CH_RBRACE:   return src_tok_pkg::KIND_RBRACE;
            src_tok_pkg::CH_LBRACKET: return src_tok_pkg::KIND_LBRACKET;
            src_tok_pkg::CH_RBRACKET: return src_tok_pkg::KIND_RBRACKET;
            src_tok_pkg::CH_DOT:      return src_tok_pkg::KIND_DOT;
            src_tok_pkg::CH_COMMA:    return src_tok_pkg::KIND_COMMA;
            default:                  return -1;
        endcase
    endfunction

    function automatic void clear_state();
        scan_mode   = src_tok_pkg::MODE_IDLE;
        held_byte   = 0;
        held_valid  = 0;
        after_cr    = 0;
        bom_matched = 0;
        byte_offset = '0;
        cur_line    = 16'd1;
        cur_col     = 16'd1;
        tok_start   = '0;
        tok_line    = 16'd1;
        tok_col     = 16'd1;
        tok_len     = '0;
        word_buffer = '0;
        is_float    = 0;
        star_seen   = 0;
    endfunction

    function automatic void push_token(logic [4:0] kind, logic [1:0] err, logic [23:0] start,
                                       logic [15:0] len, logic [15:0] line, logic [15:0] col);
        src_tok_pkg::token_t t;
        if (step_count < src_tok_pkg::MAX_RESULTS) begin
            t.token_kind   = kind;
            t.error_code   = err;
            t.token_start  = start;
            t.token_length = len;
            t.token_line   = line;
            t.token_col    = col;
            t.result_last  = 1'b0;
            expected_tokens.push_back(t);
            step_count++;
        end
    endfunction

    function automatic void emit_current(logic [4:0] kind);
        push_token(kind, src_tok_pkg::ERR_NONE, tok_start, tok_len, tok_line, tok_col);
    endfunction

    function automatic void advance(int c);
        if (byte_offset != '1) byte_offset++;
        if (c == src_tok_pkg::CH_LF) begin
            if (cur_line != '1) cur_line++;
            cur_col = 16'd1;
        end else if (cur_col != '1) begin
            cur_col++;
        end
        if (tok_len != '1) tok_len++;
    endfunction

    function automatic void open_token();
        tok_start   = byte_offset;
        tok_line    = cur_line;
        tok_col     = cur_col;
        tok_len     = '0;
        is_float    = 0;
        word_buffer = '0;
    endfunction

    function automatic logic [4:0] word_kind();
        logic [39:0] w;
        for (int i = 0; i < 8; i++) begin
            w = '0;
            for (int n = 0; n < kw_names[i].len(); n++) w = {w[31:0], kw_names[i][n]};
            if (tok_len == kw_names[i].len() && word_buffer == w)
                return src_tok_pkg::KIND_KW_BASE + 5'(i);
        end
        return src_tok_pkg::KIND_IDENT;
    endfunction

    function automatic void consume(int c, int nx);
        bit again;
        int pk;
        again = 1;
        while (again) begin
            again = 0;
            case (scan_mode)
                src_tok_pkg::MODE_IDENT: begin
                    if (word_ch(c)) begin
                        word_buffer = {word_buffer[31:0], 8'(c)};
                        advance(c);
                    end else begin
                        emit_current(word_kind());
                        scan_mode = src_tok_pkg::MODE_IDLE;
                        again = 1;
                    end
                end
                src_tok_pkg::MODE_NUM: begin
                    if (digit_ch(c) || (c == src_tok_pkg::CH_UNDERSCORE && digit_ch(nx))
                            || c == src_tok_pkg::CH_DOT) begin
                        if (c == src_tok_pkg::CH_DOT) is_float = 1;
                        advance(c);
                    end else begin
                        emit_current(is_float ? src_tok_pkg::KIND_FLOAT_LIT
                                              : src_tok_pkg::KIND_INT_LIT);
                        scan_mode = src_tok_pkg::MODE_IDLE;
                        again = 1;
                    end
                end
                src_tok_pkg::MODE_STR: begin
                    advance(c);
                    if (c == src_tok_pkg::CH_DQUOTE) begin
                        emit_current(src_tok_pkg::KIND_STR_LIT);
                        scan_mode = src_tok_pkg::MODE_IDLE;
                    end
                end
                src_tok_pkg::MODE_LINE: begin
                    if (c == src_tok_pkg::CH_LF) begin
                        scan_mode = src_tok_pkg::MODE_IDLE;
                        again = 1;
                    end else begin
                        advance(c);
                    end
                end
                src_tok_pkg::MODE_BOPEN: begin
                    advance(c);
                    scan_mode = src_tok_pkg::MODE_BLOCK;
                    star_seen = 0;
                end
                src_tok_pkg::MODE_BLOCK: begin
                    if (star_seen) begin
                        star_seen = 0;
                        scan_mode = src_tok_pkg::MODE_IDLE;
                    end else if (c == src_tok_pkg::CH_STAR && nx == src_tok_pkg::CH_SLASH) begin
                        star_seen = 1;
                    end
                    advance(c);
                end
                src_tok_pkg::MODE_DONE: ;
                default: begin
                    if (c == src_tok_pkg::CH_SPACE || c == src_tok_pkg::CH_TAB
                            || c == src_tok_pkg::CH_LF || c == src_tok_pkg::CH_CR) begin
                        advance(c);
                    end else if (c == src_tok_pkg::CH_SLASH && nx == src_tok_pkg::CH_SLASH) begin
                        advance(c);
                        scan_mode = src_tok_pkg::MODE_LINE;
                    end else if (c == src_tok_pkg::CH_SLASH && nx == src_tok_pkg::CH_STAR) begin
                        advance(c);
                        scan_mode = src_tok_pkg::MODE_BOPEN;
                    end else if (digit_ch(c) || (c == src_tok_pkg::CH_MINUS && digit_ch(nx))) begin
                        open_token();
                        advance(c);
                        scan_mode = src_tok_pkg::MODE_NUM;
                    end else if (c == src_tok_pkg::CH_DQUOTE) begin
                        open_token();
                        advance(c);
                        scan_mode = src_tok_pkg::MODE_STR;
                    end else if (alpha_ch(c) || c == src_tok_pkg::CH_UNDERSCORE) begin
                        open_token();
                        word_buffer = 40'(c);
                        advance(c);
                        scan_mode = src_tok_pkg::MODE_IDENT;
                    end else begin
                        pk = punct_of(c);
                        if (pk >= 0) begin
                            open_token();
                            advance(c);
                            emit_current(5'(pk));
                        end else begin
                            push_token(src_tok_pkg::KIND_ERR, src_tok_pkg::ERR_UNEXPECTED,
                                       byte_offset, 16'd1, cur_line, cur_col);
                            scan_mode = src_tok_pkg::MODE_DONE;
                        end
                    end
                end
            endcase
        end
    endfunction

    function automatic void feed(int c);
        if (scan_mode == src_tok_pkg::MODE_DONE) return;
        if (held_valid) consume(held_byte, c);
        held_byte  = c & 255;
        held_valid = 1;
    endfunction

    function automatic void replay_bom();
        int n;
        n = bom_matched;
        bom_matched = 3;
        if (n >= 1 && n <= 2) begin
            feed(src_tok_pkg::BOM_0);
            if (n == 2) feed(src_tok_pkg::BOM_1);
        end
    endfunction

    function automatic void flush_text();
        replay_bom();
        if (scan_mode == src_tok_pkg::MODE_DONE) return;
        if (held_valid) begin
            held_valid = 0;
            consume(held_byte, -1);
        end
        if (scan_mode == src_tok_pkg::MODE_DONE) return;
        if (scan_mode == src_tok_pkg::MODE_NUM)
            emit_current(is_float ? src_tok_pkg::KIND_FLOAT_LIT : src_tok_pkg::KIND_INT_LIT);
        else if (scan_mode == src_tok_pkg::MODE_IDENT) emit_current(word_kind());
        else if (scan_mode == src_tok_pkg::MODE_STR) begin
            push_token(src_tok_pkg::KIND_ERR, src_tok_pkg::ERR_UNTERM_STR, tok_start, tok_len,
                       tok_line, tok_col);
            scan_mode = src_tok_pkg::MODE_DONE;
            return;
        end
        push_token(src_tok_pkg::KIND_EOF, src_tok_pkg::ERR_NONE, byte_offset, 16'd0,
                   cur_line, cur_col);
        scan_mode = src_tok_pkg::MODE_DONE;
    endfunction

    function automatic void lex_byte(logic [7:0] b, bit last);
        int ch;
        bit take;
        ch = b;
        take = 1;
        step_count = 0;
        if (scan_mode != src_tok_pkg::MODE_DONE) begin
            if (bom_matched < 3) begin
                if (ch == bom_seq[bom_matched]) begin
                    bom_matched++;
                    take = 0;
                end else begin
                    replay_bom();
                end
            end
            if (take && scan_mode != src_tok_pkg::MODE_DONE) begin
                if (after_cr && ch == src_tok_pkg::CH_LF) begin
                    after_cr = 0;
                end else begin
                    after_cr = (ch == src_tok_pkg::CH_CR);
                    if (ch == src_tok_pkg::CH_CR) ch = src_tok_pkg::CH_LF;
                    if (ch == src_tok_pkg::CH_NUL) flush_text();
                    else feed(ch);
                end
            end
        end
        if (last) begin
            if (scan_mode != src_tok_pkg::MODE_DONE) flush_text();
            clear_state();
        end
        if (step_count > 0) expected_tokens[expected_tokens.size() - 1].result_last = 1'b1;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        src_tok_pkg::token_t want;
        if (!aresetn) begin
            clear_state();
            expected_tokens.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token beat, kind %0d", m_data.token_kind);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.token_kind, m_data.token_kind);
                    check_field("error_code", want.error_code, m_data.error_code);
                    check_field("token_start", want.token_start, m_data.token_start);
                    check_field("token_length", want.token_length, m_data.token_length);
                    check_field("token_line", want.token_line, m_data.token_line);
                    check_field("token_col", want.token_col, m_data.token_col);
                    check_field("result_last", want.result_last, m_data.result_last);
                end
            end
            if (s_valid && s_ready) lex_byte(s_data.src_byte, s_data.src_last);
        end
        pending = expected_tokens.size();
    end

endmodule

>>> tb/source_tokenizer_top_test.sv
// Testbench top for the source tokenizer: stimulus, idling phases and verdict.
`timescale 1ns / 100ps
module source_tokenizer_top_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;

    logic                   aclk    = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    src_tok_pkg::src_beat_t s_data  = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    src_tok_pkg::token_t    m_data;

    int fail_count;
    int pending;
    int s_idle_pct  = 0;
    int m_idle_pct  = 0;
    bit hold_req    = 0;
    int hold_left   = 0;
    int quiet_count = 0;
    int texts_sent  = 0;
    int bytes_sent  = 0;

    logic [7:0] txt[$];

    const string kw_names [8] = '{"func", "let", "mut", "uint", "int", "float", "bool", "str"};
    const string punct_chars = "+-*/%(){}[].,";

    source_tokenizer_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    token_scoreboard u_scoreboard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_count <= 0;
        else quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("source_tokenizer_top_test: errors");
            $finish;
        end
    end

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endtask

    task automatic send_beat(logic [7:0] b, bit last);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{src_byte: b, src_last: last};
        @(negedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
            @(negedge aclk);
        end
        @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < txt.size(); i++) send_beat(txt[i], i == txt.size() - 1);
        txt.delete();
        texts_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic add_fragment();
        int n;
        case ($urandom_range(0, 12))
            0, 1: push_str(kw_names[$urandom_range(0, 7)]);
            2, 3: begin
                n = $urandom_range(0, 2);
                txt.push_back(n == 0 ? src_tok_pkg::CH_UNDERSCORE :
                              n == 1 ? 8'(65 + $urandom_range(25)) : 8'(97 + $urandom_range(25)));
                repeat ($urandom_range(0, 5)) begin
                    n = $urandom_range(0, 3);
                    txt.push_back(n == 0 ? src_tok_pkg::CH_UNDERSCORE :
                                  n == 1 ? 8'(48 + $urandom_range(9))
                                         : 8'(97 + $urandom_range(25)));
                end
            end
            4, 5: begin
                if ($urandom_range(1)) txt.push_back(src_tok_pkg::CH_MINUS);
                repeat ($urandom_range(1, 3)) txt.push_back(8'(48 + $urandom_range(9)));
                if ($urandom_range(2) == 0) begin
                    txt.push_back(src_tok_pkg::CH_UNDERSCORE);
                    txt.push_back(8'(48 + $urandom_range(9)));
                end
                if ($urandom_range(2) == 0) begin
                    txt.push_back(src_tok_pkg::CH_DOT);
                    repeat ($urandom_range(0, 2)) txt.push_back(8'(48 + $urandom_range(9)));
                end
                if ($urandom_range(9) == 0) txt.push_back(src_tok_pkg::CH_UNDERSCORE);
            end
            6: begin
                txt.push_back(src_tok_pkg::CH_DQUOTE);
                repeat ($urandom_range(0, 6)) begin
                    n = $urandom_range(32, 126);
                    txt.push_back(n == src_tok_pkg::CH_DQUOTE ? src_tok_pkg::CH_SPACE : 8'(n));
                end
                txt.push_back(src_tok_pkg::CH_DQUOTE);
            end
            7: txt.push_back(punct_chars[$urandom_range(0, 12)]);
            8: txt.push_back($urandom_range(1) ? src_tok_pkg::CH_TAB : src_tok_pkg::CH_SPACE);
            9: begin
                n = $urandom_range(0, 2);
                if (n != 1) txt.push_back(src_tok_pkg::CH_CR);
                if (n != 0) txt.push_back(src_tok_pkg::CH_LF);
            end
            10: begin
                push_str("//");
                repeat ($urandom_range(0, 4)) txt.push_back(8'(97 + $urandom_range(25)));
                txt.push_back(src_tok_pkg::CH_LF);
            end
            11: begin
                push_str("/*");
                repeat ($urandom_range(0, 4))
                    txt.push_back($urandom_range(1) ? src_tok_pkg::CH_STAR
                                                    : 8'(97 + $urandom_range(25)));
                push_str("*/");
            end
            default: begin
                if ($urandom_range(3) == 0) txt.push_back(8'($urandom_range(255)));
                else txt.push_back(src_tok_pkg::CH_SPACE);
            end
        endcase
        if ($urandom_range(1)) txt.push_back(src_tok_pkg::CH_SPACE);
    endtask

    task automatic make_text();
        int tail;
        if ($urandom_range(3) == 0) begin
            txt.push_back(src_tok_pkg::BOM_0);
            txt.push_back(src_tok_pkg::BOM_1);
            txt.push_back(src_tok_pkg::BOM_2);
        end
        repeat ($urandom_range(3, 10)) add_fragment();
        tail = $urandom_range(0, 9);
        if (tail == 0) begin
            txt.push_back(src_tok_pkg::CH_NUL);
            push_str("zz");
        end else if (tail == 1) begin
            push_str("\"ab");
        end else if (tail == 2) begin
            push_str("/*x");
        end
    endtask

    task automatic run_phase(int s_pct, int m_pct, bit with_hold);
        int start_bytes;
        s_idle_pct  = s_pct;
        m_idle_pct  = m_pct;
        start_bytes = bytes_sent;
        if (with_hold) hold_req = 1;
        while (bytes_sent - start_bytes < 40) begin
            make_text();
            send_text();
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // BOM, keyword, minus number with underscore, CRLF, string
        txt.push_back(src_tok_pkg::BOM_0);
        txt.push_back(src_tok_pkg::BOM_1);
        txt.push_back(src_tok_pkg::BOM_2);
        push_str("int -3_4");
        txt.push_back(src_tok_pkg::CH_CR);
        txt.push_back(src_tok_pkg::CH_LF);
        push_str("\"s\"");
        send_text();
        // partial mark lexed as text
        txt.push_back(src_tok_pkg::BOM_0);
        txt.push_back(src_tok_pkg::BOM_1);
        push_str("A");
        send_text();
        // unterminated string
        push_str("\"ab");
        send_text();
        // minus, open block comment, zero byte, discarded tail
        push_str("-/*");
        txt.push_back(src_tok_pkg::CH_NUL);
        txt.push_back(8'hFF);
        send_text();
        drain();

        run_phase(0, 0, 1);
        run_phase(83, 0, 0);
        run_phase(0, 83, 0);
        run_phase(30, 30, 0);

        repeat (10) @(posedge aclk);
        $display("covered %0d source texts, %0d bytes, four idling phases and one long hold-off",
                 texts_sent, bytes_sent);
        if (fail_count == 0) begin
            $display("source_tokenizer_top_test: clean");
        end else begin
            $display("source_tokenizer_top_test: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/src_tok_pkg.sv
hdl/src_tok_lexer.sv
hdl/src_tok_out_buf.sv
hdl/source_tokenizer_top.sv
tb/token_scoreboard.sv
tb/source_tokenizer_top_test.sv
